// ----- sv/csv_fbs_pkg.sv -----
// Shared types, constants and the per-byte scan function of the CSV field boundary scanner.
package csv_fbs_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int OUT_OFFSET_W = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_DELIMITER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_PER_CHUNK = 3'd5;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0]  separator_char;
    logic [7:0]  row_delimiter_char;
    logic [7:0]  quote_char;
    logic [7:0]  escape_char;
    logic [15:0] columns_expected;
    logic [31:0] rows_per_chunk;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    separator_char:     8'd44,
    row_delimiter_char: 8'd10,
    quote_char:         8'd34,
    escape_char:        8'd34,
    columns_expected:   16'd1,
    rows_per_chunk:     32'd65535
  };

  typedef struct packed {
    logic                   inside_quotes;
    logic [7:0]             previous_byte;
    logic                   previous_valid;
    logic [OFFSET_BITS-1:0] chunk_offset;
    logic [15:0]            fields_in_row;
    logic [31:0]            rows_in_chunk;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    inside_quotes:  1'b0,
    previous_byte:  8'd0,
    previous_valid: 1'b0,
    chunk_offset:   '0,
    fields_in_row:  16'd1,
    rows_in_chunk:  32'd0
  };

  typedef struct packed {
    logic [OUT_OFFSET_W-1:0] field_end_offset;
    logic                    row_end;
    logic                    column_mismatch;
    logic                    chunk_end;
    logic                    run_last;
  } result_t;

  typedef struct packed {
    scan_state_t st;
    logic        produced;
    result_t     res;
  } step_t;

  // Offset truncated or zero-extended to the output width.
  function automatic logic [OUT_OFFSET_W-1:0] out_offset(input logic [OFFSET_BITS-1:0] off);
    logic [OFFSET_BITS+OUT_OFFSET_W-1:0] wide;
    wide = {{OUT_OFFSET_W{1'b0}}, off};
    return wide[OUT_OFFSET_W-1:0];
  endfunction

  function automatic step_t scan_step(input scan_state_t s, input logic [7:0] b,
                                      input cfg_t c);
    step_t       r;
    logic        is_quote;
    logic        escaped;
    logic        is_row;
    logic        field_end;
    logic        close;
    logic [31:0] limit;
    r        = '0;
    r.st     = s;
    is_quote = (b == c.quote_char);
    escaped  = (c.quote_char != c.escape_char) && s.previous_valid &&
               (s.previous_byte == c.escape_char);
    is_row   = (b == c.row_delimiter_char);
    field_end = !is_quote && !s.inside_quotes && (is_row || (b == c.separator_char));
    limit    = (c.rows_per_chunk == 32'd0) ? 32'd1 : c.rows_per_chunk;
    close    = field_end && is_row &&
               ({1'b0, s.rows_in_chunk} + 33'd1 >= {1'b0, limit});

    if (is_quote && !escaped) begin
      r.st.inside_quotes = !s.inside_quotes;
    end
    if (field_end) begin
      if (is_row) begin
        r.st.fields_in_row = 16'd1;
        if (!close) begin
          r.st.rows_in_chunk = s.rows_in_chunk + 32'd1;
        end
      end else if (s.fields_in_row != 16'hFFFF) begin
        r.st.fields_in_row = s.fields_in_row + 16'd1;
      end
      r.produced             = 1'b1;
      r.res.field_end_offset = out_offset(s.chunk_offset);
      r.res.row_end          = is_row;
      r.res.column_mismatch  = is_row && (s.fields_in_row != c.columns_expected);
      r.res.chunk_end        = close;
      r.res.run_last         = 1'b0;
    end

    if (close) begin
      r.st = SCAN_RESET;
    end else begin
      r.st.previous_byte  = b;
      r.st.previous_valid = 1'b1;
      if (s.chunk_offset != {OFFSET_BITS{1'b1}}) begin
        r.st.chunk_offset = s.chunk_offset + OFFSET_BITS'(1);
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/csv_fbs_data_if.sv -----
// Input byte channel of the CSV field boundary scanner.
interface csv_fbs_data_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ----- sv/csv_fbs_result_if.sv -----
// Result channel of the CSV field boundary scanner.
interface csv_fbs_result_if import csv_fbs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OUT_OFFSET_W-1:0] field_end_offset;
  logic                    row_end;
  logic                    column_mismatch;
  logic                    chunk_end;
  logic                    run_last;

  modport source (output valid, output field_end_offset, output row_end,
                  output column_mismatch, output chunk_end, output run_last, input ready);
  modport sink (input valid, input field_end_offset, input row_end,
                input column_mismatch, input chunk_end, input run_last, output ready);
endinterface

// ----- sv/csv_fbs_cfg_if.sv -----
// Configuration write channel of the CSV field boundary scanner.
interface csv_fbs_cfg_if import csv_fbs_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- sv/csv_field_boundary_scanner.sv -----
// CSV field boundary scanner: one byte per cycle while data.ready is high, 0 to 2 field-end results per byte.
// Results are registered in the result queue and presented on the result channel from its head.
// Throughput: 1 byte per cycle while data.ready is high; the 4-entry result queue drains 1 result per cycle
// while result.ready is high, and data.ready is low while the queue cannot take two more results.
// Reset (rst, synchronous): scan state cleared, registers back to defaults, queue emptied.
module csv_field_boundary_scanner import csv_fbs_pkg::*; (
  input logic              clk,
  input logic              rst,
  csv_fbs_cfg_if.sink      cfg,
  csv_fbs_data_if.sink     data,
  csv_fbs_result_if.source result
);

  cfg_t        regs;
  scan_state_t state;
  scan_state_t state_next;

  result_t          fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;

  step_t   s1;
  step_t   s2;
  logic    need_second;
  logic    p2;
  logic    take;
  logic    pop;
  logic [1:0] n_push;
  result_t e0;
  result_t e1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_SEPARATOR:      regs.separator_char <= cfg.wdata[7:0];
        CFG_ROW_DELIMITER:  regs.row_delimiter_char <= cfg.wdata[7:0];
        CFG_QUOTE:          regs.quote_char <= cfg.wdata[7:0];
        CFG_ESCAPE:         regs.escape_char <= cfg.wdata[7:0];
        CFG_COLUMNS:        regs.columns_expected <= cfg.wdata[15:0];
        CFG_ROWS_PER_CHUNK: regs.rows_per_chunk <= cfg.wdata[31:0];
        default: ;
      endcase
    end
  end

  assign data.ready = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign take       = data.valid && data.ready;
  assign pop        = result.valid && result.ready;

  // Second pass supplies the missing row delimiter at the end of the file.
  assign s1          = scan_step(state, data.data_byte, regs);
  assign need_second = data.final_byte && (data.data_byte != regs.row_delimiter_char);
  assign s2          = scan_step(s1.st, regs.row_delimiter_char, regs);
  assign p2          = need_second && s2.produced;

  always_comb begin
    e0     = s1.res;
    e1     = s2.res;
    n_push = 2'd0;
    if (s1.produced && p2) begin
      e1.run_last = 1'b1;
      n_push      = 2'd2;
    end else if (s1.produced) begin
      e0.run_last = 1'b1;
      n_push      = 2'd1;
    end else if (p2) begin
      e0          = s2.res;
      e0.run_last = 1'b1;
      n_push      = 2'd1;
    end
    if (!take) begin
      n_push = 2'd0;
    end

    state_next = state;
    if (take) begin
      state_next = data.final_byte ? SCAN_RESET : s1.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SCAN_RESET;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      rd_ptr <= pop ? rd_ptr + PTR_W'(1) : rd_ptr;
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      count  <= count + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo[wr_ptr] <= e0;
    end
    if (n_push == 2'd2) begin
      fifo[wr_ptr + PTR_W'(1)] <= e1;
    end
  end

  assign result.valid            = (count != '0);
  assign result.field_end_offset = fifo[rd_ptr].field_end_offset;
  assign result.row_end          = fifo[rd_ptr].row_end;
  assign result.column_mismatch  = fifo[rd_ptr].column_mismatch;
  assign result.chunk_end        = fifo[rd_ptr].chunk_end;
  assign result.run_last         = fifo[rd_ptr].run_last;

endmodule

// ----- tb/sv/csv_field_boundary_scanner_test.sv -----
// Self-checking testbench of the CSV field boundary scanner.
`timescale 1ns / 100ps

module csv_field_boundary_scanner_test;
  import csv_fbs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  logic clk = 1'b0;
  logic rst;

  csv_fbs_cfg_if cfg_ch();
  csv_fbs_data_if data_ch();
  csv_fbs_result_if res_ch();

  csv_field_boundary_scanner dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .data(data_ch),
    .result(res_ch)
  );

  always #5 clk = ~clk;

  // scanner registers as the testbench sees them
  logic [7:0] sep_c, row_c, quo_c, esc_c;
  logic [15:0] cols_c;
  logic [31:0] rows_c;

  // scan state
  bit in_quote;
  logic [7:0] prev_b;
  bit prev_ok;
  logic [OFFSET_BITS-1:0] offset;
  logic [15:0] fields;
  logic [31:0] rows_done;

  result_t expected_fields[$];

  int failures = 0;
  int bytes_sent = 0;
  int fields_checked = 0;
  int rows_seen = 0;
  int chunks_seen = 0;
  int mismatches_seen = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  result_t got;

  function automatic void clear_scan();
    in_quote = 1'b0;
    prev_b = 8'd0;
    prev_ok = 1'b0;
    offset = '0;
    fields = 16'd1;
    rows_done = 32'd0;
  endfunction

  function automatic void append_expected(input result_t r);
    expected_fields = {expected_fields, r};
  endfunction

  // One byte through the scanner; queues a field end if the byte makes one.
  function automatic int advance_scan(input logic [7:0] b);
    result_t r;
    bit closes;
    bit at_row;
    logic [31:0] lim;
    closes = 1'b0;
    advance_scan = 0;
    if (b == quo_c) begin
      if (!((quo_c != esc_c) && prev_ok && (prev_b == esc_c)))
        in_quote = !in_quote;
    end else if (!in_quote && (b == row_c || b == sep_c)) begin
      at_row = (b == row_c);
      r = '0;
      r.field_end_offset = OUT_OFFSET_W'(offset);
      r.row_end = at_row;
      if (at_row) begin
        lim = (rows_c == 32'd0) ? 32'd1 : rows_c;
        r.column_mismatch = (fields != cols_c);
        if ({1'b0, rows_done} + 33'd1 >= {1'b0, lim}) closes = 1'b1;
        else rows_done = rows_done + 32'd1;
        fields = 16'd1;
      end else if (fields != 16'hFFFF) begin
        fields = fields + 16'd1;
      end
      r.chunk_end = closes;
      append_expected(r);
      advance_scan = 1;
    end
    if (closes) begin
      clear_scan();
    end else begin
      prev_b = b;
      prev_ok = 1'b1;
      if (offset != '1) offset = offset + OFFSET_BITS'(1);
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input bit fin);
    int n;
    int last_idx;
    result_t r;
    n = advance_scan(b);
    // a file without a closing delimiter gets one supplied
    if (fin && b != row_c) n += advance_scan(row_c);
    if (fin) clear_scan();
    if (n > 0) begin
      last_idx = expected_fields.size() - 1;
      r = expected_fields[last_idx];
      r.run_last = 1'b1;
      expected_fields[last_idx] = r;
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    gap = (src_idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      data_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_ch.valid <= 1'b1;
    data_ch.data_byte <= b;
    data_ch.final_byte <= fin;
    do @(posedge clk); while (!data_ch.ready);
    predict_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  // Holds the sender until all field ends are back, then lets in-flight bytes settle.
  task automatic wait_idle();
    data_ch.valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_SEPARATOR: sep_c = val[7:0];
      CFG_ROW_DELIMITER: row_c = val[7:0];
      CFG_QUOTE: quo_c = val[7:0];
      CFG_ESCAPE: esc_c = val[7:0];
      CFG_COLUMNS: cols_c = val[15:0];
      CFG_ROWS_PER_CHUNK: rows_c = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] sep, input logic [7:0] row,
                              input logic [7:0] quo, input logic [7:0] esc,
                              input logic [15:0] cols, input logic [31:0] rows);
    wait_idle();
    write_reg(CFG_SEPARATOR, {24'd0, sep});
    write_reg(CFG_ROW_DELIMITER, {24'd0, row});
    write_reg(CFG_QUOTE, {24'd0, quo});
    write_reg(CFG_ESCAPE, {24'd0, esc});
    write_reg(CFG_COLUMNS, {16'd0, cols});
    write_reg(CFG_ROWS_PER_CHUNK, rows);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Result side: random stalls, compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_idle && $urandom_range(0, 9) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_fields.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected field end: offset=%0d row_end=%0b", res_ch.field_end_offset,
                   res_ch.row_end);
      end else begin
        got = expected_fields.pop_front();
        fields_checked++;
        rows_seen += got.row_end;
        chunks_seen += got.chunk_end;
        mismatches_seen += got.column_mismatch;
        if (res_ch.field_end_offset !== got.field_end_offset ||
            res_ch.row_end !== got.row_end ||
            res_ch.column_mismatch !== got.column_mismatch ||
            res_ch.chunk_end !== got.chunk_end || res_ch.run_last !== got.run_last) begin
          failures++;
          if (failures <= 10) begin
            $display("field end %0d: expected off=%0d row=%0b mis=%0b chunk=%0b last=%0b",
                     fields_checked, got.field_end_offset, got.row_end,
                     got.column_mismatch, got.chunk_end, got.run_last);
            $display("  got off=%0d row=%0b mis=%0b chunk=%0b last=%0b",
                     res_ch.field_end_offset, res_ch.row_end, res_ch.column_mismatch,
                     res_ch.chunk_end, res_ch.run_last);
          end
        end
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((data_ch.valid && data_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d field ends pending", idle_cycles,
               expected_fields.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_default_registers();
    // separator adds a field, so the row is one field too long
    send_text("a,b\n", 1'b0);
    // last byte without delimiter
    send_byte("z", 1'b1);
  endtask

  task automatic test_quote_on_separator();
    // all-zero / all-one bytes; the quote shadows the separator, every row closes a chunk
    program_regs(8'h00, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 32'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b1);
    // file ends inside an open quote: the supplied delimiter gives nothing
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_escape_shared_delimiter();
    // separator equal to the delimiter, escape distinct from the quote
    program_regs(CH_LF, CH_LF, CH_QUOTE, CH_BSLASH, 16'd2, 32'hFFFF_FFFF);
    send_text("\\\"\n\"\\\"\n\"\n", 1'b1);
  endtask

  task automatic test_escape_at_chunk_start();
    // escape byte 0 matches the cleared look-back, which must not count at chunk start
    program_regs(CH_COMMA, CH_LF, CH_QUOTE, 8'h00, 16'd1, 32'd1);
    send_text("\n\",\"", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("\",\n", 1'b1);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] set_of[8];
    set_of = '{CH_COMMA, CH_LF, CH_QUOTE, CH_BSLASH, 8'h3B, 8'h09, 8'h7C, 8'h27};
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return set_of[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == sep_c || b == row_c || b == quo_c);
    return b;
  endfunction

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 9))
      0: return sep_c;
      1: return row_c;
      2: return quo_c;
      3: return esc_c;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_field();
    int len;
    logic [7:0] b;
    len = $urandom_range(0, 4);
    if ($urandom_range(0, 2) == 0) begin
      send_byte(quo_c, 1'b0);
      repeat (len) begin
        case ($urandom_range(0, 5))
          0: send_byte(sep_c, 1'b0);
          1: send_byte(row_c, 1'b0);
          2: begin
            // escaped or doubled quote inside quoted content
            send_byte((esc_c != quo_c) ? esc_c : quo_c, 1'b0);
            send_byte(quo_c, 1'b0);
          end
          default: begin
            do b = 8'($urandom_range(0, 255)); while (b == quo_c);
            send_byte(b, 1'b0);
          end
        endcase
      end
      send_byte(quo_c, 1'b0);
    end else begin
      repeat (len) send_byte(plain_byte(), 1'b0);
    end
  endtask

  task automatic send_row();
    int nf;
    if (cols_c <= 16'd6 && $urandom_range(0, 3) != 0) nf = int'(cols_c);
    else nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      send_field();
      if (f < nf - 1) send_byte(sep_c, 1'b0);
    end
    send_byte(row_c, $urandom_range(0, 19) == 0);
  endtask

  task automatic test_random_text();
    int stop_at;
    bit paused;
    logic [15:0] cols;
    logic [31:0] rows;
    for (int phase = 0; phase < 5; phase++) begin
      cols = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 4)) :
                                          16'($urandom_range(1, 65535));
      case ($urandom_range(0, 9))
        0: rows = 32'hFFFF_FFFF;
        1: rows = $urandom;
        2, 3: rows = $urandom_range(5, 20);
        default: rows = $urandom_range(1, 4);
      endcase
      program_regs(pick_char(), pick_char(), pick_char(), pick_char(), cols, rows);
      src_idle = (phase != 1);
      sink_idle = (phase != 1);
      stop_at = bytes_sent + 90;
      paused = 1'b0;
      while (bytes_sent < stop_at) begin
        if (!paused && bytes_sent >= stop_at - 45) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) != 0) begin
          send_row();
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(noisy_byte(), $urandom_range(0, 29) == 0);
        end
      end
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    data_ch.valid <= 1'b0;
    data_ch.data_byte <= 8'd0;
    data_ch.final_byte <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= CFG_SEPARATOR;
    cfg_ch.wdata <= 32'd0;
    sep_c = CFG_RESET.separator_char;
    row_c = CFG_RESET.row_delimiter_char;
    quo_c = CFG_RESET.quote_char;
    esc_c = CFG_RESET.escape_char;
    cols_c = CFG_RESET.columns_expected;
    rows_c = CFG_RESET.rows_per_chunk;
    clear_scan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_quote_on_separator();
    test_escape_shared_delimiter();
    test_escape_at_chunk_start();
    test_random_text();

    wait_idle();
    repeat (5) @(posedge clk);
    $display("Covered %0d bytes under %0d register settings: %0d field ends checked,",
             bytes_sent, settings_used + 1, fields_checked);
    $display("  %0d row ends, %0d chunk closes, %0d column mismatches, %0d failures",
             rows_seen, chunks_seen, mismatches_seen, failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
